@@ rtl/ktjfs_pkg.sv @@
// Package for the keyed table with jump and Fibonacci search.
// Holds table sizing, op and status codes, and the shared entry and compare types.
// No dependencies.
package ktjfs_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 7;
    localparam int WW          = CNT_W + 1;
    localparam int STOCK_W     = 16;
    localparam int SERIAL_W    = 32;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_UPDATE = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_JUMP   = 3'd3;
    localparam logic [2:0] OP_FIB    = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [STOCK_W-1:0]  stock;
        logic [SERIAL_W-1:0] serial;
    } t_entry;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

endpackage

@@ rtl/ktjfs_mem.sv @@
// Entry storage: one write port and one read port with registered read data.
// Depends on ktjfs_pkg for the entry type and table depth.
module ktjfs_mem
    import ktjfs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    // Write one entry and read one entry each cycle; a read sees the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ktjfs_cmp.sv @@
// Shared key compare unit used by every key comparison of both searches.
// Depends on ktjfs_pkg for the compare result type.
module ktjfs_cmp
    import ktjfs_pkg::*;
(
    input  logic [STOCK_W-1:0] i_stock,
    input  logic [STOCK_W-1:0] i_key,
    output t_cmp               o_cmp
);

    // Order the stored stock value against the search key
    always_comb begin
        o_cmp.lt = (i_stock < i_key);
        o_cmp.eq = (i_stock == i_key);
    end

endmodule

@@ rtl/keyed_table_jump_fibonacci_search.sv @@
// Keyed table with jump and Fibonacci search; one operation per transaction.
// Each operation runs as a sequence of states through the table memory, which has one
// write port and one read port, and through one key comparator. One item at a time.
// Reset clears the entry count and the sequencer; table contents stay undefined.
module keyed_table_jump_fibonacci_search
    import ktjfs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_op,
    input  logic [CNT_W-1:0]    i_position,
    input  logic [STOCK_W-1:0]  i_stock_value,
    input  logic [SERIAL_W-1:0] i_serial_value,
    input  logic [STOCK_W-1:0]  i_search_key,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output logic [CNT_W-1:0]    o_found_position,
    output logic [STOCK_W-1:0]  o_found_stock,
    output logic [SERIAL_W-1:0] o_found_serial,
    output logic [CNT_W-1:0]    o_entry_total
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_INS_SH  = 5'd1;
    localparam logic [4:0] S_INS_WR  = 5'd2;
    localparam logic [4:0] S_UPD     = 5'd3;
    localparam logic [4:0] S_DEL_RD  = 5'd4;
    localparam logic [4:0] S_DEL_CAP = 5'd5;
    localparam logic [4:0] S_DEL_SH  = 5'd6;
    localparam logic [4:0] S_J_SQ    = 5'd7;
    localparam logic [4:0] S_J_BRD   = 5'd8;
    localparam logic [4:0] S_J_BCMP  = 5'd9;
    localparam logic [4:0] S_J_LIN   = 5'd10;
    localparam logic [4:0] S_J_LCMP  = 5'd11;
    localparam logic [4:0] S_F_INIT  = 5'd12;
    localparam logic [4:0] S_F_RD    = 5'd13;
    localparam logic [4:0] S_F_CMP   = 5'd14;
    localparam logic [4:0] S_F_FIN   = 5'd15;
    localparam logic [4:0] S_DONE    = 5'd16;

    logic [4:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_pos, n_pos;
    logic [STOCK_W-1:0]  r_stock, n_stock;
    logic [SERIAL_W-1:0] r_serial, n_serial;
    logic [STOCK_W-1:0]  r_key, n_key;
    logic [CNT_W-1:0]    r_k, n_k;
    logic                r_wpend, n_wpend;
    logic [IDX_W-1:0]    r_wdst, n_wdst;
    logic [WW-1:0]       r_lo, n_lo;
    logic [WW-1:0]       r_hi, n_hi;
    logic [WW-1:0]       r_sr, n_sr;
    logic [WW-1:0]       r_sq, n_sq;
    logic [WW-1:0]       r_f, n_f;
    logic [WW-1:0]       r_f1, n_f1;
    logic [WW-1:0]       r_f2, n_f2;
    logic [WW-1:0]       r_o1, n_o1;
    logic [WW-1:0]       r_i, n_i;
    logic [1:0]          r_res_status, n_res_status;
    logic [CNT_W-1:0]    r_res_pos, n_res_pos;
    logic [STOCK_W-1:0]  r_res_stock, n_res_stock;
    logic [SERIAL_W-1:0] r_res_serial, n_res_serial;
    logic                r_out_valid;
    logic [1:0]          r_out_status;
    logic [CNT_W-1:0]    r_out_pos;
    logic [STOCK_W-1:0]  r_out_stock;
    logic [SERIAL_W-1:0] r_out_serial;
    logic [CNT_W-1:0]    r_out_total;

    logic                in_acc;
    logic                out_free;
    logic                out_load;
    logic [WW-1:0]       cnt_w;
    logic [WW-1:0]       hi_min;
    logic [WW-1:0]       fib_t;
    logic [WW-1:0]       fib_i;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    t_entry              mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;
    t_entry              mem_rdata;
    t_cmp                cmp;

    ktjfs_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ktjfs_cmp u_cmp (
        .i_stock (mem_rdata.stock),
        .i_key   (r_key),
        .o_cmp   (cmp)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign out_load = (r_state == S_DONE) && out_free;

    // Search bounds: count, jump high bound and Fibonacci probe index
    assign cnt_w  = {1'b0, r_count};
    assign hi_min = (r_hi < cnt_w) ? r_hi : cnt_w;
    assign fib_t  = r_o1 + r_f2;
    always_comb begin
        fib_i = (fib_t == '0) ? '0 : fib_t - WW'(1);
        if (fib_i > cnt_w - WW'(1)) begin
            fib_i = cnt_w - WW'(1);
        end
    end

    // Steer the single write port: a pending shift write takes priority
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wdst;
        mem_wdata = mem_rdata;
        if (r_wpend) begin
            mem_we = 1'b1;
        end else if (r_state == S_INS_WR) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '{stock: r_stock, serial: r_serial};
        end else if (r_state == S_UPD) begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(r_pos - CNT_W'(1));
            mem_wdata = '{stock: r_stock, serial: r_serial};
        end
    end

    // Sequence one operation through the table
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_stock      = r_stock;
        n_serial     = r_serial;
        n_key        = r_key;
        n_k          = r_k;
        n_wpend      = 1'b0;
        n_wdst       = r_wdst;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_sr         = r_sr;
        n_sq         = r_sq;
        n_f          = r_f;
        n_f1         = r_f1;
        n_f2         = r_f2;
        n_o1         = r_o1;
        n_i          = r_i;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        n_res_stock  = r_res_stock;
        n_res_serial = r_res_serial;
        mem_raddr    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_pos        = i_position;
                    n_stock      = i_stock_value;
                    n_serial     = i_serial_value;
                    n_key        = i_search_key;
                    n_res_status = ST_MISS;
                    n_res_pos    = '0;
                    n_res_stock  = '0;
                    n_res_serial = '0;
                    n_state      = S_DONE;
                    case (i_op)
                        OP_INSERT: begin
                            if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                n_k     = r_count;
                                n_state = S_INS_SH;
                            end
                        end
                        OP_UPDATE: begin
                            if (i_position != '0 && i_position <= r_count) begin
                                n_state = S_UPD;
                            end
                        end
                        OP_DELETE: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end else if (i_position != '0 && i_position <= r_count) begin
                                n_k     = i_position - CNT_W'(1);
                                n_state = S_DEL_RD;
                            end
                        end
                        OP_JUMP: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_sr    = '0;
                                n_sq    = WW'(1);
                                n_state = S_J_SQ;
                            end
                        end
                        OP_FIB: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_f2    = '0;
                                n_f1    = WW'(1);
                                n_f     = WW'(1);
                                n_o1    = '0;
                                n_state = S_F_INIT;
                            end
                        end
                        default: begin
                            n_res_status = ST_MISS;
                        end
                    endcase
                end
            end

            // Shift entries back one place, back to front
            S_INS_SH: begin
                if (r_k != '0) begin
                    mem_raddr = IDX_W'(r_k - CNT_W'(1));
                    n_wpend   = 1'b1;
                    n_wdst    = IDX_W'(r_k);
                    n_k       = r_k - CNT_W'(1);
                end else begin
                    n_state = S_INS_WR;
                end
            end

            S_INS_WR: begin
                n_count      = r_count + CNT_W'(1);
                n_res_status = ST_OK;
                n_res_pos    = CNT_W'(1);
                n_res_stock  = r_stock;
                n_res_serial = r_serial;
                n_state      = S_DONE;
            end

            S_UPD: begin
                n_res_status = ST_OK;
                n_res_pos    = r_pos;
                n_res_stock  = r_stock;
                n_res_serial = r_serial;
                n_state      = S_DONE;
            end

            // Read the entry being removed
            S_DEL_RD: begin
                mem_raddr = IDX_W'(r_k);
                n_state   = S_DEL_CAP;
            end

            S_DEL_CAP: begin
                n_res_status = ST_OK;
                n_res_pos    = r_pos;
                n_res_stock  = mem_rdata.stock;
                n_res_serial = mem_rdata.serial;
                n_state      = S_DEL_SH;
            end

            // Close the gap, front to back
            S_DEL_SH: begin
                if (r_k + CNT_W'(1) < r_count) begin
                    mem_raddr = IDX_W'(r_k + CNT_W'(1));
                    n_wpend   = 1'b1;
                    n_wdst    = IDX_W'(r_k);
                    n_k       = r_k + CNT_W'(1);
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end

            // Integer square root of the count, one step per cycle
            S_J_SQ: begin
                if (r_sq <= cnt_w) begin
                    n_sr = r_sr + WW'(1);
                    n_sq = r_sq + {r_sr[WW-2:0], 1'b0} + WW'(3);
                end else begin
                    n_lo    = '0;
                    n_hi    = r_sr;
                    n_state = S_J_BRD;
                end
            end

            S_J_BRD: begin
                mem_raddr = IDX_W'(hi_min - WW'(1));
                n_state   = S_J_BCMP;
            end

            S_J_BCMP: begin
                if (!cmp.lt) begin
                    n_state = S_J_LIN;
                end else begin
                    n_lo = r_hi;
                    n_hi = r_hi + r_sr;
                    if (r_hi >= cnt_w) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_J_BRD;
                    end
                end
            end

            S_J_LIN: begin
                if (r_lo < hi_min) begin
                    mem_raddr = IDX_W'(r_lo);
                    n_state   = S_J_LCMP;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_J_LCMP: begin
                if (cmp.lt) begin
                    n_lo    = r_lo + WW'(1);
                    n_state = S_J_LIN;
                end else begin
                    if (cmp.eq) begin
                        n_res_status = ST_OK;
                        n_res_pos    = CNT_W'(r_lo + WW'(1));
                        n_res_stock  = mem_rdata.stock;
                        n_res_serial = mem_rdata.serial;
                    end
                    n_state = S_DONE;
                end
            end

            // Grow the Fibonacci numbers until they cover the count
            S_F_INIT: begin
                if (r_f < cnt_w) begin
                    n_f2 = r_f1;
                    n_f1 = r_f;
                    n_f  = r_f + r_f1;
                end else begin
                    n_state = S_F_RD;
                end
            end

            S_F_RD: begin
                if (r_f > WW'(1)) begin
                    mem_raddr = IDX_W'(fib_i);
                    n_i       = fib_i;
                    n_state   = S_F_CMP;
                end else if (r_f1 != '0 && r_o1 < cnt_w) begin
                    mem_raddr = IDX_W'(r_o1);
                    n_i       = r_o1;
                    n_state   = S_F_FIN;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_F_CMP: begin
                if (cmp.lt) begin
                    n_f     = r_f1;
                    n_f1    = r_f2;
                    n_f2    = r_f1 - r_f2;
                    n_o1    = r_i + WW'(1);
                    n_state = S_F_RD;
                end else if (!cmp.eq) begin
                    n_f     = r_f2;
                    n_f1    = r_f1 - r_f2;
                    n_f2    = r_f2 - (r_f1 - r_f2);
                    n_state = S_F_RD;
                end else begin
                    n_res_status = ST_OK;
                    n_res_pos    = CNT_W'(r_i + WW'(1));
                    n_res_stock  = mem_rdata.stock;
                    n_res_serial = mem_rdata.serial;
                    n_state      = S_DONE;
                end
            end

            S_F_FIN: begin
                if (cmp.eq) begin
                    n_res_status = ST_OK;
                    n_res_pos    = CNT_W'(r_i + WW'(1));
                    n_res_stock  = mem_rdata.stock;
                    n_res_serial = mem_rdata.serial;
                end
                n_state = S_DONE;
            end

            // Hold until the output register is free
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wpend <= n_wpend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_stock      <= n_stock;
        r_serial     <= n_serial;
        r_key        <= n_key;
        r_k          <= n_k;
        r_wdst       <= n_wdst;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_sr         <= n_sr;
        r_sq         <= n_sq;
        r_f          <= n_f;
        r_f1         <= n_f1;
        r_f2         <= n_f2;
        r_o1         <= n_o1;
        r_i          <= n_i;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_res_stock  <= n_res_stock;
        r_res_serial <= n_res_serial;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_pos    <= r_res_pos;
            r_out_stock  <= r_res_stock;
            r_out_serial <= r_res_serial;
            r_out_total  <= r_count;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_position = r_out_pos;
    assign o_found_stock    = r_out_stock;
    assign o_found_serial   = r_out_serial;
    assign o_entry_total    = r_out_total;

endmodule
